@@ src/tsch_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer scheduler package
// Shared types and constants for the timer scheduler block: request opcodes,
// field widths of the stream channels and the scan control bundle.
// ----------------------------------------------------------------------------
package tsch_pkg;

   // Request opcodes carried in req_tuser.
   typedef enum logic [1:0] {
      OP_ARM    = 2'd0,
      OP_CANCEL = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_TICK   = 2'd3
   } opcode_type;

   // Fixed field widths of the channels.
   localparam int SLOT_ID_W   = 4;
   localparam int IVL_W       = 31;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 8;

   // At most this many slots fire on one tick.
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // Control bundle that steps the scan unit through one pass.
   typedef struct packed {
      logic clear;     // start a new pass, forget the best candidate
      logic valid;     // slot memory read data is present this cycle
      logic eligible;  // slot is armed and has not fired on this tick yet
   } scan_ctl_type;

endpackage

@@ src/tsch_slot_ram.sv @@
// ----------------------------------------------------------------------------
// Timer slot memory
// One write port and one read port, read data registered.
// Each word holds a slot's interval above its deadline.
// ----------------------------------------------------------------------------
module tsch_slot_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 63,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/tsch_scan.sv @@
// ----------------------------------------------------------------------------
// Timer scan unit
// Watches one slot per cycle during a pass and keeps the most overdue
// eligible slot. Slots arrive in ascending id order, so a strict compare
// keeps the lower id when two slots are equally late.
// ----------------------------------------------------------------------------
module tsch_scan
   import tsch_pkg::*;
#(
   parameter int TIME_BITS = 32,
   parameter int SLOT_W    = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  scan_ctl_type         ctl,
   input  logic [SLOT_W-1:0]    slot,
   input  logic [TIME_BITS-1:0] now,
   input  logic [TIME_BITS-1:0] deadline,
   input  logic [IVL_W-1:0]     interval,
   output logic                 found,
   output logic [SLOT_W-1:0]    best_slot,
   output logic [IVL_W-1:0]     best_ivl
);

   logic                 found_ff, found_in;
   logic [TIME_BITS-1:0] best_late_ff, best_late_in;
   logic [SLOT_W-1:0]    best_slot_ff, best_slot_in;
   logic [IVL_W-1:0]     best_ivl_ff, best_ivl_in;
   logic [TIME_BITS-1:0] late;
   logic                 due;

   // A slot is due when now minus its deadline is not negative.
   assign late = now - deadline;
   assign due  = ctl.valid && ctl.eligible && !late[TIME_BITS-1];

   // Keep the candidate with the largest lateness.
   always_comb begin
      found_in     = found_ff;
      best_late_in = best_late_ff;
      best_slot_in = best_slot_ff;
      best_ivl_in  = best_ivl_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (due && (!found_ff || late > best_late_ff)) begin
         found_in     = 1'b1;
         best_late_in = late;
         best_slot_in = slot;
         best_ivl_in  = interval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_late_ff <= best_late_in;
      best_slot_ff <= best_slot_in;
      best_ivl_ff  <= best_ivl_in;
   end

   assign found     = found_ff;
   assign best_slot = best_slot_ff;
   assign best_ivl  = best_ivl_ff;

endmodule

@@ src/timer_scheduler.sv @@
// ----------------------------------------------------------------------------
// Timer scheduler
// Table of timer slots with arm, cancel, clear and tick requests; each tick
// emits the due slots, most overdue first, and re-arms the repeating ones.
// ----------------------------------------------------------------------------
// Arm, cancel and clear requests are taken in ST_IDLE, which they do not
// leave. A tick holds the request port while it runs: each fired slot costs
// one full pass over the slot memory, which is read one slot per cycle, and
// one final pass finds that no further slot is due. When sixteen slots fire,
// no final pass is run. A stall on the result side lengthens a tick.
// Deadlines and intervals live in the slot memory; armed and repeat flags
// are flip-flops cleared by reset. A result waiting in the output register
// does not keep the block from taking the next request.
// ----------------------------------------------------------------------------
module timer_scheduler
   import tsch_pkg::*;
#(
   parameter int TIMER_SLOTS = 16,
   parameter int TIME_BITS   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: slot_id[3:0], interval_ticks[34:4], repeat_mode[35], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: opcode[1:0]
   input  logic [1:0]            req_tuser,
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: fired_slot[3:0], rearmed[4], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tlast: last_fired
   output logic                  rsp_tlast
);

   localparam int SLOT_W = $clog2(TIMER_SLOTS);
   localparam int WORD_W = TIME_BITS + IVL_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_WAIT   = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_FLUSH  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIMER_SLOTS-1:0] active_ff, active_in;
   logic [TIMER_SLOTS-1:0] repeat_ff, repeat_in;
   logic [TIMER_SLOTS-1:0] done_ff, done_in;
   logic [SLOT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                 issue_valid_ff, issue_valid_in;
   logic [SLOT_W-1:0]    issue_slot_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [SLOT_ID_W-1:0] pend_slot_ff, pend_slot_in;
   logic                 pend_rep_ff, pend_rep_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_ID_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                 rsp_rep_ff, rsp_rep_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Request fields.
   opcode_type           req_opcode;
   logic [SLOT_ID_W-1:0] req_slot_id;
   logic [IVL_W-1:0]     req_interval;
   logic                 req_repeat;
   logic [IVL_W-1:0]     arm_ivl;
   logic [SLOT_W-1:0]    req_slot;
   logic                 req_in_table;
   logic                 req_accept;

   // Memory and scan unit connections.
   logic                 ram_wr_en;
   logic [SLOT_W-1:0]    ram_wr_addr;
   logic [WORD_W-1:0]    ram_wr_data;
   logic [WORD_W-1:0]    ram_rd_data;
   scan_ctl_type         scan_ctl;
   logic                 scan_found;
   logic [SLOT_W-1:0]    scan_best_slot;
   logic [IVL_W-1:0]     scan_best_ivl;
   logic                 out_free;
   logic                 pass_start;

   assign req_opcode   = opcode_type'(req_tuser);
   assign req_slot_id  = req_tdata[3:0];
   assign req_interval = req_tdata[34:4];
   assign req_repeat   = req_tdata[35];
   assign arm_ivl      = (req_interval == '0) ? IVL_W'(1) : req_interval;
   assign req_slot     = SLOT_W'(req_slot_id);
   assign req_in_table = int'(req_slot_id) < TIMER_SLOTS;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Slot memory.
   tsch_slot_ram #(
      .DEPTH  (TIMER_SLOTS),
      .WIDTH  (WORD_W),
      .ADDR_W (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rd_data)
   );

   // Scan unit sees the slot whose read was issued in the previous cycle.
   assign scan_ctl.clear    = pass_start;
   assign scan_ctl.valid    = issue_valid_ff;
   assign scan_ctl.eligible = active_ff[issue_slot_ff] && !done_ff[issue_slot_ff];

   tsch_scan #(
      .TIME_BITS (TIME_BITS),
      .SLOT_W    (SLOT_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .slot      (issue_slot_ff),
      .now       (now_ff),
      .deadline  (ram_rd_data[TIME_BITS-1:0]),
      .interval  (ram_rd_data[WORD_W-1:TIME_BITS]),
      .found     (scan_found),
      .best_slot (scan_best_slot),
      .best_ivl  (scan_best_ivl)
   );

   // Sequencer: requests, scan passes and result hand-off.
   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      active_in      = active_ff;
      repeat_in      = repeat_ff;
      done_in        = done_ff;
      scan_idx_in    = scan_idx_ff;
      issue_valid_in = 1'b0;
      count_in       = count_ff;
      pend_valid_in  = pend_valid_ff;
      pend_slot_in   = pend_slot_ff;
      pend_rep_in    = pend_rep_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_slot_in    = rsp_slot_ff;
      rsp_rep_in     = rsp_rep_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = req_slot;
      ram_wr_data    = {arm_ivl, now_ff + TIME_BITS'(arm_ivl)};
      pass_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            pass_start  = 1'b1;
            scan_idx_in = '0;
            if (req_accept) begin
               unique case (req_opcode)
                  OP_ARM: begin
                     if (req_in_table) begin
                        ram_wr_en           = 1'b1;
                        active_in[req_slot] = 1'b1;
                        repeat_in[req_slot] = req_repeat;
                     end
                  end
                  OP_CANCEL: begin
                     if (req_in_table) begin
                        active_in[req_slot] = 1'b0;
                     end
                  end
                  OP_CLEAR: begin
                     active_in = '0;
                  end
                  OP_TICK: begin
                     now_in        = now_ff + TIME_BITS'(1);
                     done_in       = '0;
                     count_in      = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
               endcase
            end
         end

         // Issue one slot read per cycle.
         ST_SCAN: begin
            issue_valid_in = 1'b1;
            scan_idx_in    = scan_idx_ff + SLOT_W'(1);
            if (scan_idx_ff == SLOT_W'(TIMER_SLOTS - 1)) begin
               scan_idx_in = '0;
               state_in    = ST_WAIT;
            end
         end

         // Last read data reaches the scan unit.
         ST_WAIT: begin
            state_in = ST_DECIDE;
         end

         // Fire the best slot of this pass; the previous one goes out now
         // that it is known not to be the last.
         ST_DECIDE: begin
            if (out_free) begin
               if (scan_found) begin
                  done_in[scan_best_slot] = 1'b1;
                  if (repeat_ff[scan_best_slot]) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = scan_best_slot;
                     ram_wr_data = {scan_best_ivl, now_ff + TIME_BITS'(scan_best_ivl)};
                  end else begin
                     active_in[scan_best_slot] = 1'b0;
                  end
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_slot_in  = pend_slot_ff;
                     rsp_rep_in   = pend_rep_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = SLOT_ID_W'(scan_best_slot);
                  pend_rep_in   = repeat_ff[scan_best_slot];
                  count_in      = count_ff + CNT_W'(1);
                  if (count_ff == CNT_W'(MAX_RESULTS - 1)) begin
                     state_in = ST_FLUSH;
                  end else begin
                     pass_start = 1'b1;
                     state_in   = ST_SCAN;
                  end
               end else if (pend_valid_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         // Send the final result of the tick.
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = pend_slot_ff;
               rsp_rep_in    = pend_rep_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         now_ff         <= '0;
         active_ff      <= '0;
         repeat_ff      <= '0;
         done_ff        <= '0;
         scan_idx_ff    <= '0;
         issue_valid_ff <= 1'b0;
         count_ff       <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         now_ff         <= now_in;
         active_ff      <= active_in;
         repeat_ff      <= repeat_in;
         done_ff        <= done_in;
         scan_idx_ff    <= scan_idx_in;
         issue_valid_ff <= issue_valid_in;
         count_ff       <= count_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      issue_slot_ff <= scan_idx_ff;
      pend_slot_ff  <= pend_slot_in;
      pend_rep_ff   <= pend_rep_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_rep_ff    <= rsp_rep_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_rep_ff, rsp_slot_ff};
   assign rsp_tlast  = rsp_last_ff;

   // No more results than the per-tick limit.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RESULTS))
      else $error("fired count exceeds the per-tick limit");

   // The slot memory is never written while a pass is reading it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_WAIT) |-> !ram_wr_en)
      else $error("slot memory written during a scan pass");

   // A fired slot is excluded from the rest of the tick.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && out_free && scan_found)
      |=> done_ff[$past(scan_best_slot)])
      else $error("fired slot not marked done");

   // A new request never arrives with a result still held back.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !pend_valid_ff)
      else $error("request accepted while a tick result is pending");

endmodule

@@ sim/tb_timer_scheduler.sv @@
// ----------------------------------------------------------------------------
// Timer scheduler testbench
// Drives arm, cancel, clear and tick requests into the timer scheduler and
// checks every fired-slot item against a cycle-free predictor of the slot
// table or a typed row's outcome. A short directed table walks the special
// cases first; random sequences follow, including a full table of repeating
// slots while the result side holds off, so the block backs up into its request port.
// ----------------------------------------------------------------------------
module tb_timer_scheduler
   import tsch_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS    = 16;
   localparam int RANDOM_ITEMS = 155;
   localparam int STORM_AT     = 60;
   localparam int STORM_TICKS  = 6;
   localparam int HOLD_CYCLES  = 600;
   localparam int TAIL_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 400000;

   // One request as the block sees it.
   typedef struct {
      opcode_type          op;
      logic [SLOT_ID_W-1:0] slot;
      logic [IVL_W-1:0]     ivl;
      logic                 rep;
   } req_item_type;

   // One fired-slot item.
   typedef struct {
      logic [SLOT_ID_W-1:0] slot;
      logic                 rearmed;
      logic                 last;
   } fire_type;

   // Directed row: request plus an optional hand-written outcome.
   typedef struct {
      opcode_type          op;
      logic [SLOT_ID_W-1:0] slot;
      logic [IVL_W-1:0]     ivl;
      logic                 rep;
      bit                   typed;
      bit                   fires;
      logic [SLOT_ID_W-1:0] f_slot;
      logic                 f_rearm;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = OP_CLEAR;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   timer_scheduler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Predicted slot table.
   logic [31:0]          sched_time;
   logic [31:0]          sched_deadline [NUM_SLOTS];
   logic [IVL_W-1:0]     sched_interval [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] sched_armed;
   logic [NUM_SLOTS-1:0] sched_repeat;

   fire_type tick_fires[$];
   fire_type expected_fires[$];

   int  errors         = 0;
   int  requests_sent  = 0;
   int  ticks_sent     = 0;
   int  fires_checked  = 0;
   int  most_fires     = 0;
   int  holds_done     = 0;
   int  burst_left     = 1;
   int  cycle_count    = 0;
   bit  hold_pending   = 1'b0;

   // Directed stimulus: reset behavior, zero and maximum interval, one-shot
   // and repeat, cancel of an armed and an idle slot, re-arm in place,
   // clear all, and several slots due on the same tick.
   dir_row_type dir_table [27] = '{
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_ARM,    4'd0,  31'd0,          1'b0, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b1, 1'b1, 4'd0,  1'b0},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_ARM,    4'd15, 31'd0,          1'b1, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b1, 1'b1, 4'd15, 1'b1},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b1, 1'b1, 4'd15, 1'b1},
      '{OP_CANCEL, 4'd15, 31'd0,          1'b0, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_CANCEL, 4'd3,  31'd0,          1'b0, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_ARM,    4'd5,  31'h7FFF_FFFF,  1'b1, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_ARM,    4'd6,  31'd2,          1'b0, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_ARM,    4'd7,  31'd2,          1'b1, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_ARM,    4'd8,  31'd1,          1'b0, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b1, 1'b1, 4'd8,  1'b0},
      '{OP_ARM,    4'd7,  31'd3,          1'b1, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b1, 1'b1, 4'd6,  1'b0},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b1, 1'b1, 4'd7,  1'b1},
      '{OP_CLEAR,  4'd0,  31'd0,          1'b0, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b1, 1'b0, 4'd0,  1'b0},
      '{OP_ARM,    4'd9,  31'd3,          1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
      '{OP_ARM,    4'd2,  31'd3,          1'b1, 1'b0, 1'b0, 4'd0,  1'b0},
      '{OP_ARM,    4'd12, 31'd1,          1'b1, 1'b0, 1'b0, 4'd0,  1'b0},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b0, 1'b0, 4'd0,  1'b0},
      '{OP_TICK,   4'd0,  31'd0,          1'b0, 1'b0, 1'b0, 4'd0,  1'b0}
   };

   // Clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d fired slots still pending",
                  $time, cycle_count, expected_fires.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Apply one request to the predicted table and collect the slots it fires.
   function automatic void predict_request(input req_item_type it);
      logic [IVL_W-1:0] period;
      logic [31:0]      lateness [NUM_SLOTS];
      int               order [NUM_SLOTS];
      logic [31:0]      diff;
      int               n;
      int               j;
      fire_type         f;
      tick_fires.delete();
      case (it.op)
         OP_ARM: begin
            period = (it.ivl == '0) ? IVL_W'(1) : it.ivl;
            sched_interval[it.slot] = period;
            sched_repeat[it.slot]   = it.rep;
            sched_deadline[it.slot] = sched_time + 32'(period);
            sched_armed[it.slot]    = 1'b1;
         end
         OP_CANCEL: sched_armed[it.slot] = 1'b0;
         OP_CLEAR:  sched_armed = '0;
         default: begin
            sched_time = sched_time + 32'd1;
            n = 0;
            // Collect due slots, most overdue first, lower id first on ties.
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (sched_armed[s]) begin
                  diff = sched_time - sched_deadline[s];
                  if (!diff[31]) begin
                     j = n;
                     while (j > 0 && lateness[j-1] < diff) begin
                        lateness[j] = lateness[j-1];
                        order[j]    = order[j-1];
                        j--;
                     end
                     lateness[j] = diff;
                     order[j]    = s;
                     n++;
                  end
               end
            end
            if (n > MAX_RESULTS) n = MAX_RESULTS;
            // Fire them: repeat slots move on by their interval.
            for (int k = 0; k < n; k++) begin
               f.slot    = SLOT_ID_W'(order[k]);
               f.rearmed = sched_repeat[order[k]];
               f.last    = (k == n - 1);
               if (f.rearmed)
                  sched_deadline[order[k]] = sched_time + 32'(sched_interval[order[k]]);
               else
                  sched_armed[order[k]] = 1'b0;
               tick_fires.push_back(f);
            end
         end
      endcase
   endfunction

   // Offer one request, wait for it to be taken, queue its fired slots, then
   // pace the sender in bursts. A typed row replaces the predicted outcome.
   task automatic send_request(input req_item_type it, input bit closing, input bit typed,
                               input bit t_fires, input fire_type t_fire);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {4'b0, it.rep, it.ivl, it.slot};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      predict_request(it);
      if (typed) begin
         if (t_fires) expected_fires.push_back(t_fire);
      end else begin
         foreach (tick_fires[k]) expected_fires.push_back(tick_fires[k]);
      end
      requests_sent++;
      if (it.op == OP_TICK) begin
         ticks_sent++;
         if (tick_fires.size() > most_fires) most_fires = tick_fires.size();
      end
      burst_left--;
      gap = 0;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (closing || gap > 0) req_tvalid <= 1'b0;
      if (gap > 0) repeat (gap) @(posedge clock);
   endtask

   // Result side: stretches of always-ready, random and mostly-stalled
   // acceptance, plus one long hold-off on request.
   initial begin
      int  stretch;
      int  mode;
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            stretch = $urandom_range(1, 40);
            mode    = $urandom_range(0, 2);
            repeat (stretch) begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Compare each fired slot with the oldest outstanding prediction.
   always @(posedge clock) begin
      fire_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_fires.size() == 0) begin
            $display("%0t: unexpected fired slot %0d rearmed %0d last %0d",
                     $time, rsp_tdata[3:0], rsp_tdata[4], rsp_tlast);
            errors++;
         end else begin
            want = expected_fires.pop_front();
            fires_checked++;
            if (rsp_tdata[3:0] !== want.slot || rsp_tdata[4] !== want.rearmed ||
                rsp_tlast !== want.last) begin
               $display("%0t: mismatch, expected slot %0d rearmed %0d last %0d, %s",
                        $time, want.slot, want.rearmed, want.last, "got:");
               $display("%0t:    actual slot %0d rearmed %0d last %0d",
                        $time, rsp_tdata[3:0], rsp_tdata[4], rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      req_item_type it;
      fire_type     tf;
      int           random_sent;
      int           pick;
      sched_time   = '0;
      sched_armed  = '0;
      sched_repeat = '0;
      foreach (sched_deadline[s]) begin
         sched_deadline[s] = '0;
         sched_interval[s] = '0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      foreach (dir_table[r]) begin
         it.op      = dir_table[r].op;
         it.slot    = dir_table[r].slot;
         it.ivl     = dir_table[r].ivl;
         it.rep     = dir_table[r].rep;
         tf.slot    = dir_table[r].f_slot;
         tf.rearmed = dir_table[r].f_rearm;
         tf.last    = 1'b1;
         send_request(it, 1'b0, dir_table[r].typed, dir_table[r].fires, tf);
      end

      // Random part.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent == STORM_AT) begin
            // Every slot repeating with the shortest period, result side held off.
            for (int s = 0; s < NUM_SLOTS; s++) begin
               it.op   = OP_ARM;
               it.slot = SLOT_ID_W'(s);
               it.ivl  = IVL_W'($urandom_range(0, 1));
               it.rep  = 1'b1;
               send_request(it, 1'b0, 1'b0, 1'b0, tf);
               random_sent++;
            end
            hold_pending = 1'b1;
            it.op = OP_TICK;
            repeat (STORM_TICKS) begin
               send_request(it, 1'b0, 1'b0, 1'b0, tf);
               random_sent++;
            end
            it.op = OP_CLEAR;
            send_request(it, 1'b0, 1'b0, 1'b0, tf);
            random_sent++;
         end else begin
            pick    = $urandom_range(0, 99);
            it.slot = SLOT_ID_W'($urandom_range(0, NUM_SLOTS - 1));
            it.rep  = 1'($urandom_range(0, 1));
            it.op   = (pick < 38) ? OP_ARM : (pick < 50) ? OP_CANCEL :
                      (pick < 53) ? OP_CLEAR : OP_TICK;
            // Mostly short periods so that slots come due often.
            pick = $urandom_range(0, 99);
            if (pick < 70)      it.ivl = IVL_W'($urandom_range(0, 6));
            else if (pick < 85) it.ivl = IVL_W'($urandom_range(7, 40));
            else if (pick < 95) it.ivl = IVL_W'($urandom);
            else                it.ivl = '1;
            send_request(it, random_sent == RANDOM_ITEMS - 1, 1'b0, 1'b0, tf);
            random_sent++;
         end
      end

      // Drain, then watch for stray items.
      while (expected_fires.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d ticks); checked %0d fired slots, up to %0d on one tick.",
               requests_sent, ticks_sent, fires_checked, most_fires);
      $display("Result side held off %0d time(s) for %0d cycles with requests still offered.",
               holds_done, HOLD_CYCLES);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d error(s) found", errors);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/tsch_pkg.sv
src/tsch_slot_ram.sv
src/tsch_scan.sv
src/timer_scheduler.sv
sim/tb_timer_scheduler.sv
